@@ rtl/bounded_indexed_list_engine_defines.svh @@
// Assertion macros for the list engine. They expand to nothing under synthesis.
`ifndef BOUNDED_INDEXED_LIST_ENGINE_DEFINES_SVH
`define BOUNDED_INDEXED_LIST_ENGINE_DEFINES_SVH
`ifndef SYNTHESIS
`define BILE_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("list engine assertion failed");
`define BILE_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("list engine assertion failed");
`else
`define BILE_ASSERT_IMP(label, clk, rstn, ante, cons)
`define BILE_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

@@ rtl/bile_pkg.sv @@
package bile_pkg;

    localparam int BILE_MAX_ENTRIES = 16;

    localparam logic [2:0] OP_APPEND = 3'd0;
    localparam logic [2:0] OP_INSERT = 3'd1;
    localparam logic [2:0] OP_REMOVE = 3'd2;
    localparam logic [2:0] OP_POP    = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;

    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    localparam logic [31:0] FAIL_VALUE  = 32'hFFFF_FFFF;
    localparam logic [4:0]  CAPACITY_RESET = 5'd16;

    typedef struct packed {
        logic [2:0]         op;
        logic [3:0]         position;
        logic signed [31:0] data_in;
    } in_beat_t;

    typedef struct packed {
        logic signed [31:0] data_out;
        logic [1:0]         status;
        logic [4:0]         count;
    } out_beat_t;

endpackage

@@ rtl/bounded_indexed_list_engine.sv @@
// A rejected operation goes straight to the result register. Append writes the entry at the
// end and read returns the entry from the store; insert first moves each entry from position on
// up by one and remove or pop moves each later entry down by one, through the single store port.
// The input is ready again once the result is registered, so no new beat is taken before the
// last one is done; a result held by the receiver stalls only the next result.
// Synchronous reset empties the list and sets capacity to 16; the store is not cleared.
module bounded_indexed_list_engine
    import bile_pkg::*;
#(
    parameter int MAX_ENTRIES = BILE_MAX_ENTRIES
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cfg_wr_en,
    input  logic [4:0] cfg_wr_data,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    localparam int IW = $clog2(MAX_ENTRIES);

    logic [4:0]    capacity_reg;
    logic          mem_en;
    logic          mem_we;
    logic [IW-1:0] mem_addr;
    logic [31:0]   mem_wdata;
    logic [31:0]   mem_rdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAPACITY_RESET;
        end else if (cfg_wr_en) begin
            capacity_reg <= cfg_wr_data;
        end
    end

    bile_ctrl #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .capacity  (capacity_reg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .mem_en    (mem_en),
        .mem_we    (mem_we),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata)
    );

    bile_mem #(
        .DEPTH(MAX_ENTRIES)
    ) u_mem (
        .aclk      (aclk),
        .mem_en    (mem_en),
        .mem_we    (mem_we),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata)
    );

endmodule

@@ rtl/bile_mem.sv @@
module bile_mem
    import bile_pkg::*;
#(
    parameter int DEPTH = BILE_MAX_ENTRIES,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          mem_en,
    input  logic          mem_we,
    input  logic [AW-1:0] mem_addr,
    input  logic [31:0]   mem_wdata,
    output logic [31:0]   mem_rdata
);

    logic [31:0] store [DEPTH];

    always_ff @(posedge aclk) begin
        if (mem_en) begin
            if (mem_we) begin
                store[mem_addr] <= mem_wdata;
            end else begin
                mem_rdata <= store[mem_addr];
            end
        end
    end

endmodule

@@ rtl/bile_ctrl.sv @@
`include "bounded_indexed_list_engine_defines.svh"

module bile_ctrl
    import bile_pkg::*;
#(
    parameter int MAX_ENTRIES = BILE_MAX_ENTRIES,
    localparam int IW = $clog2(MAX_ENTRIES),
    localparam int LW = $clog2(MAX_ENTRIES + 1)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [4:0]    capacity,
    input  logic          s_valid,
    output logic          s_ready,
    input  in_beat_t      s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output out_beat_t     m_data,
    output logic          mem_en,
    output logic          mem_we,
    output logic [IW-1:0] mem_addr,
    output logic [31:0]   mem_wdata,
    input  logic [31:0]   mem_rdata
);

    localparam int CW = (LW > 5) ? LW : 5;
    localparam int EW = LW + 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SH_RD,
        S_SH_WR,
        S_INS_PUT,
        S_RM_VAL,
        S_RM_RD,
        S_RM_WR,
        S_RD_VAL,
        S_FIN
    } state_t;

    state_t          state_reg;
    logic [LW-1:0]   len_reg;
    logic [IW-1:0]   idx_reg;
    logic [IW-1:0]   pos_reg;
    logic [31:0]     data_reg;
    logic [31:0]     res_data_reg;
    logic [1:0]      res_status_reg;
    logic            m_valid_reg;
    out_beat_t       m_data_reg;

    logic            full;
    logic            pos_in_list;
    logic            ins_pos_ok;
    logic            rm_first_more;
    logic            rm_more;
    logic [IW-1:0]   len_idx;
    logic [IW-1:0]   last_idx;

    assign full = (CW'(len_reg) >= CW'(capacity)) || (len_reg >= LW'(MAX_ENTRIES));
    assign pos_in_list = CW'(s_data.position) < CW'(len_reg);
    assign ins_pos_ok = pos_in_list || (len_reg == '0 && s_data.position == '0);
    assign rm_first_more = (EW'(idx_reg) + EW'(1)) < EW'(len_reg);
    assign rm_more = (EW'(idx_reg) + EW'(2)) < EW'(len_reg);
    assign len_idx = IW'(len_reg);
    assign last_idx = IW'(len_reg - LW'(1));

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;

    always_comb begin
        mem_en = 1'b0;
        mem_we = 1'b0;
        mem_addr = '0;
        mem_wdata = data_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    case (s_data.op) inside
                        OP_REMOVE, OP_READ: begin
                            if (pos_in_list) begin
                                mem_en = 1'b1;
                                mem_addr = IW'(s_data.position);
                            end
                        end
                        OP_POP: begin
                            if (len_reg != '0) begin
                                mem_en = 1'b1;
                                mem_addr = last_idx;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SH_RD: begin
                mem_en = 1'b1;
                mem_addr = idx_reg - IW'(1);
            end
            S_SH_WR, S_RM_WR: begin
                mem_en = 1'b1;
                mem_we = 1'b1;
                mem_addr = idx_reg;
                mem_wdata = mem_rdata;
            end
            S_INS_PUT: begin
                mem_en = 1'b1;
                mem_we = 1'b1;
                mem_addr = pos_reg;
            end
            S_RM_VAL: begin
                if (rm_first_more) begin
                    mem_en = 1'b1;
                    mem_addr = idx_reg + IW'(1);
                end
            end
            S_RM_RD: begin
                mem_en = 1'b1;
                mem_addr = idx_reg + IW'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            len_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != S_FIN) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        data_reg <= s_data.data_in;
                        res_data_reg <= FAIL_VALUE;
                        res_status_reg <= STATUS_RANGE;
                        state_reg <= S_FIN;
                        case (s_data.op) inside
                            OP_APPEND: begin
                                if (full) begin
                                    res_status_reg <= STATUS_FULL;
                                end else begin
                                    pos_reg <= len_idx;
                                    state_reg <= S_INS_PUT;
                                end
                            end
                            OP_INSERT: begin
                                if (ins_pos_ok && full) begin
                                    res_status_reg <= STATUS_FULL;
                                end else if (ins_pos_ok) begin
                                    pos_reg <= IW'(s_data.position);
                                    idx_reg <= len_idx;
                                    if (len_idx == IW'(s_data.position)) begin
                                        state_reg <= S_INS_PUT;
                                    end else begin
                                        state_reg <= S_SH_RD;
                                    end
                                end
                            end
                            OP_REMOVE: begin
                                if (pos_in_list) begin
                                    idx_reg <= IW'(s_data.position);
                                    state_reg <= S_RM_VAL;
                                end
                            end
                            OP_POP: begin
                                if (len_reg != '0) begin
                                    idx_reg <= last_idx;
                                    state_reg <= S_RM_VAL;
                                end
                            end
                            OP_READ: begin
                                if (pos_in_list) begin
                                    state_reg <= S_RD_VAL;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SH_RD: begin
                    state_reg <= S_SH_WR;
                end
                S_SH_WR: begin
                    idx_reg <= idx_reg - IW'(1);
                    if ((idx_reg - IW'(1)) == pos_reg) begin
                        state_reg <= S_INS_PUT;
                    end else begin
                        state_reg <= S_SH_RD;
                    end
                end
                S_INS_PUT: begin
                    len_reg <= len_reg + LW'(1);
                    res_data_reg <= '0;
                    res_status_reg <= STATUS_DONE;
                    state_reg <= S_FIN;
                end
                S_RM_VAL: begin
                    res_data_reg <= mem_rdata;
                    res_status_reg <= STATUS_DONE;
                    if (rm_first_more) begin
                        state_reg <= S_RM_WR;
                    end else begin
                        len_reg <= len_reg - LW'(1);
                        state_reg <= S_FIN;
                    end
                end
                S_RM_RD: begin
                    state_reg <= S_RM_WR;
                end
                S_RM_WR: begin
                    idx_reg <= idx_reg + IW'(1);
                    if (rm_more) begin
                        state_reg <= S_RM_RD;
                    end else begin
                        len_reg <= len_reg - LW'(1);
                        state_reg <= S_FIN;
                    end
                end
                S_RD_VAL: begin
                    res_data_reg <= mem_rdata;
                    res_status_reg <= STATUS_DONE;
                    state_reg <= S_FIN;
                end
                S_FIN: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg.data_out <= res_data_reg;
                        m_data_reg.status <= res_status_reg;
                        m_data_reg.count <= 5'(len_reg);
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `BILE_ASSERT_IMP(a_len_bound, aclk, aresetn, 1'b1, len_reg <= LW'(MAX_ENTRIES))
    `BILE_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    `BILE_ASSERT_NXT(a_idle_len_hold, aclk, aresetn, state_reg == S_IDLE && !s_valid, $stable(len_reg))

endmodule
